[src/lldc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the LogLog distinct counter.
package lldc_pkg;

    localparam int CMD_W     = 2;
    localparam int HEAD_W    = 32;
    localparam int TAIL_W    = 64;
    localparam int CFG_W     = 4;
    localparam int BITS_W    = 5;
    localparam int RHO_W     = 7;
    localparam int RANK_W    = 8;
    localparam int SUM_W     = 24;
    localparam int EST_W     = 31;
    localparam int FRAC_W    = 16;
    localparam int P_W       = 32;
    localparam int SCALE_W   = 29;

    localparam logic [CFG_W-1:0]   RESET_INDEX_BITS = 4'd10;
    localparam logic [BITS_W-1:0]  MIN_INDEX_BITS   = 5'd4;
    localparam logic [RHO_W-1:0]   RHO_ZERO_TAIL    = 7'd65;
    localparam logic [P_W-1:0]     ONE_Q30          = 32'h4000_0000;
    localparam logic [63:0]        HALF_Q30         = 64'h2000_0000;
    localparam logic [SCALE_W-1:0] SCALE_Q30        = 29'd426286242;
    localparam logic [EST_W-1:0]   EST_SAT          = 31'h7FFF_FFFF;

    // 2^(2^-(k+1)) in Q30, for index k = 0 .. 15
    localparam logic [P_W-1:0] POW2_FRAC_Q30 [16] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
        32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_EST    = 2'd1,
        CMD_CLR    = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [BITS_W-1:0] bits;
    } t_cfg_write;

    typedef struct packed {
        logic clearing;
        logic s1_busy;
        logic est_busy;
    } t_back_status;

    function automatic logic [BITS_W-1:0] f_active_bits(input logic [CFG_W-1:0] raw,
                                                        input int unsigned max_bits);
        logic [BITS_W-1:0] b;
        b = BITS_W'(raw);
        if (b < MIN_INDEX_BITS) begin
            b = MIN_INDEX_BITS;
        end else if (b > BITS_W'(max_bits)) begin
            b = BITS_W'(max_bits);
        end
        return b;
    endfunction

endpackage

[src/lldc_front.sv]
`timescale 1ns / 1ps
// Front end: takes input transfers, derives register index and rho, feeds the queue.
module lldc_front #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic [lldc_pkg::BITS_W-1:0]   i_bits,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lldc_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lldc_pkg::HEAD_W-1:0]   i_hash_head,
    input  logic [lldc_pkg::TAIL_W-1:0]   i_hash_tail,
    input  logic                          i_space,
    output logic                          o_push,
    output lldc_pkg::t_cmd                o_cmd,
    output logic [MAX_INDEX_BITS-1:0]     o_idx,
    output logic [lldc_pkg::RHO_W-1:0]    o_rho
);
    import lldc_pkg::*;

    logic               fire;
    logic [HEAD_W-1:0]  head_shr;
    logic [RHO_W-1:0]   rho;

    assign o_in_ready = i_space;
    assign fire       = i_in_valid && i_space;

    // unused command code is taken and dropped here
    assign o_push = fire && (t_cmd'(i_cmd) != CMD_UNUSED);
    assign o_cmd  = t_cmd'(i_cmd);

    assign head_shr = i_hash_head >> (6'd32 - 6'(i_bits));
    assign o_idx    = head_shr[MAX_INDEX_BITS-1:0];

    // trailing-zero count plus one
    always_comb begin
        rho = RHO_ZERO_TAIL;
        for (int i = TAIL_W - 1; i >= 0; i--) begin
            if (i_hash_tail[i]) begin
                rho = RHO_W'(i + 1);
            end
        end
    end
    assign o_rho = rho;

endmodule

[src/lldc_fifo.sv]
`timescale 1ns / 1ps
// Small register queue between front end and back end.
module lldc_fifo #(
    parameter int W     = 21,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_space,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_space = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[src/lldc_est.sv]
`timescale 1ns / 1ps
// Iterative estimate unit: one Q30 multiply per cycle, holds its result until taken.
module lldc_est (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lldc_pkg::SUM_W-1:0]    i_sum,
    input  logic [lldc_pkg::BITS_W-1:0]   i_bits,
    output logic                          o_idle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lldc_pkg::EST_W-1:0]    o_estimate
);
    import lldc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FRAC  = 5'b00010,
        ST_KMUL  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [P_W-1:0]      r_p;
    logic [FRAC_W-1:0]   r_frac;
    logic [SUM_W-1:0]    r_e;
    logic [3:0]          r_k;
    logic [63:0]         r_v;
    logic [EST_W-1:0]    r_est;

    logic [SUM_W-1:0]    m;
    logic [SUM_W-1:0]    s_u;
    logic [SUM_W-1:0]    ip;
    logic [SUM_W-1:0]    s_lo;
    logic [FRAC_W-1:0]   frac;
    logic [63:0]         frac_prod;
    logic [63:0]         frac_rnd;
    logic [5:0]          sh;
    logic [63:0]         shifted;

    assign m     = SUM_W'(1) << i_bits;
    assign s_u   = i_sum + m;
    assign ip    = s_u >> i_bits;
    assign s_lo  = (s_u & (m - SUM_W'(1))) << (BITS_W'(FRAC_W) - i_bits);
    assign frac  = s_lo[FRAC_W-1:0];

    assign frac_prod = 64'(r_p) * 64'(POW2_FRAC_Q30[r_k]);
    assign frac_rnd  = frac_prod + HALF_Q30;

    assign sh      = 6'd60 - r_e[5:0];
    assign shifted = r_v >> sh;

    assign o_idle     = (r_state == ST_IDLE);
    assign o_valid    = (r_state == ST_DONE);
    assign o_estimate = r_est;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_FRAC;
            ST_FRAC:  if (r_k == 4'd15) n_state = ST_KMUL;
            ST_KMUL:  n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_DONE;
            ST_DONE:  if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_p    <= ONE_Q30;
                r_k    <= '0;
                r_frac <= frac;
                r_e    <= ip + SUM_W'(i_bits) - SUM_W'(1);
            end
            ST_FRAC: begin
                if (r_frac[4'd15 - r_k]) begin
                    r_p <= frac_rnd[61:30];
                end
                r_k <= r_k + 4'd1;
            end
            ST_KMUL: begin
                r_v <= 64'(r_p) * 64'(SCALE_Q30);
            end
            ST_SHIFT: begin
                if (r_e >= SUM_W'(60) || shifted > 64'(EST_SAT)) begin
                    r_est <= EST_SAT;
                end else begin
                    r_est <= shifted[EST_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/lldc_back.sv]
`timescale 1ns / 1ps
// Back end: rank memory read-modify-write, clearing pass, running sum, estimate.
module lldc_back #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lldc_pkg::BITS_W-1:0]   i_bits,
    input  lldc_pkg::t_cfg_write          i_cfg,
    input  logic                          i_head_valid,
    input  lldc_pkg::t_cmd                i_head_cmd,
    input  logic [MAX_INDEX_BITS-1:0]     i_head_idx,
    input  logic [lldc_pkg::RHO_W-1:0]    i_head_rho,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lldc_pkg::EST_W-1:0]    o_estimate,
    output lldc_pkg::t_back_status        o_status
);
    import lldc_pkg::*;

    localparam int DEPTH = 2 ** MAX_INDEX_BITS;
    localparam logic [BITS_W-1:0] RESET_ACTIVE =
        f_active_bits(RESET_INDEX_BITS, MAX_INDEX_BITS);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(0) - (SUM_W'(1) << RESET_ACTIVE);

    logic [RANK_W-1:0]         r_rank_mem [DEPTH];
    logic [RANK_W-1:0]         r_rd;

    logic                      r_clr_busy;
    logic [MAX_INDEX_BITS-1:0] r_clr_pos;
    logic [RANK_W-1:0]         r_clr_val;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_s1_valid;
    logic [MAX_INDEX_BITS-1:0] r_s1_idx;
    logic [RHO_W-1:0]          r_s1_rho;
    logic                      r_fwd_valid;
    logic [MAX_INDEX_BITS-1:0] r_fwd_idx;
    logic [RANK_W-1:0]         r_fwd_val;

    logic                      pop;
    logic                      add_pop;
    logic                      clr_pop;
    logic                      est_start;
    logic                      est_idle;
    logic [MAX_INDEX_BITS-1:0] last_pos;
    logic [RANK_W-1:0]         old_rank;
    logic signed [8:0]         old_s;
    logic signed [8:0]         rho_s;
    logic signed [8:0]         delta;
    logic                      s1_we;
    logic                      mem_we;
    logic [MAX_INDEX_BITS-1:0] mem_wa;
    logic [RANK_W-1:0]         mem_wd;

    always_comb begin
        pop = 1'b0;
        if (i_head_valid && !i_cfg.we) begin
            case (i_head_cmd)
                CMD_ADD: pop = !r_clr_busy;
                CMD_EST: pop = !r_s1_valid && est_idle;
                CMD_CLR: pop = !r_clr_busy && !r_s1_valid;
                default: pop = 1'b1;
            endcase
        end
    end

    assign o_pop     = pop;
    assign add_pop   = pop && (i_head_cmd == CMD_ADD);
    assign clr_pop   = pop && (i_head_cmd == CMD_CLR);
    assign est_start = pop && (i_head_cmd == CMD_EST);

    assign last_pos = ~({MAX_INDEX_BITS{1'b1}} << i_bits);

    // write of the item one ahead lands on the same edge as this item's read
    assign old_rank = (r_fwd_valid && r_fwd_idx == r_s1_idx) ? r_fwd_val : r_rd;
    assign old_s    = {old_rank[RANK_W-1], old_rank};
    assign rho_s    = {2'b00, r_s1_rho};
    assign delta    = rho_s - old_s;
    assign s1_we    = r_s1_valid && (rho_s > old_s);

    assign mem_we = r_clr_busy || s1_we;
    assign mem_wa = r_clr_busy ? r_clr_pos : r_s1_idx;
    assign mem_wd = r_clr_busy ? r_clr_val : RANK_W'(r_s1_rho);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rank_mem[mem_wa] <= mem_wd;
        end
        if (add_pop) begin
            r_rd <= r_rank_mem[i_head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_pos   <= '0;
            r_clr_val   <= '1;
            r_sum       <= SUM_RESET;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_cfg.we) begin
            r_clr_busy  <= 1'b1;
            r_clr_pos   <= '0;
            r_clr_val   <= '1;
            r_sum       <= SUM_W'(0) - (SUM_W'(1) << i_cfg.bits);
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= add_pop;
            r_fwd_valid <= s1_we;
            if (clr_pop) begin
                r_clr_busy <= 1'b1;
                r_clr_pos  <= '0;
                r_clr_val  <= '0;
                r_sum      <= '0;
            end else begin
                if (r_clr_busy) begin
                    r_clr_pos <= r_clr_pos + MAX_INDEX_BITS'(1);
                    if (r_clr_pos == last_pos) begin
                        r_clr_busy <= 1'b0;
                    end
                end
                if (s1_we) begin
                    r_sum <= r_sum + {{(SUM_W-9){delta[8]}}, delta};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_head_idx;
        r_s1_rho  <= i_head_rho;
        r_fwd_idx <= r_s1_idx;
        r_fwd_val <= RANK_W'(r_s1_rho);
    end

    lldc_est u_est (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (est_start),
        .i_sum      (r_sum),
        .i_bits     (i_bits),
        .o_idle     (est_idle),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_estimate (o_estimate)
    );

    assign o_status.clearing = r_clr_busy;
    assign o_status.s1_busy  = r_s1_valid;
    assign o_status.est_busy = !est_idle;

endmodule

[src/loglog_distinct_counter_top.sv]
`timescale 1ns / 1ps
// LogLog distinct counter: add hashes, read estimates, clear the sketch.
//
// Input channel (i_in_valid / o_in_ready) carries cmd, hash_head, hash_tail:
// add, estimate request or clear. Output channel (o_out_valid / i_out_ready)
// carries one estimate for each estimate request, in order. The config channel
// (i_cfg_valid / o_cfg_ready, always ready) writes index_bits and restarts the
// sketch. Transfers enter a two-entry queue; the back end drains it.
// Adds: one per cycle while no sweep runs, read-modify-write of the rank memory with
// forwarding of the previous add's write. An estimate passes the queue, then 16 Q30
// multiply steps, one scale multiply and one shift/saturate step. Adds behind it
// keep flowing while it runs or waits.
// Clear: a sweep over 2^index_bits memory rows, one row per cycle; adds and
// further clears wait for it. Reset and every config write start the same
// sweep writing -1 (over 1024 rows after reset); estimates are served meanwhile.
// If the receiver stalls, the result is held and a further estimate request
// waits at the queue head, holding what follows; the input side stalls once
// the queue fills.
module loglog_distinct_counter_top #(
    parameter int MAX_INDEX_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lldc_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lldc_pkg::HEAD_W-1:0]   i_hash_head,
    input  logic [lldc_pkg::TAIL_W-1:0]   i_hash_tail,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lldc_pkg::EST_W-1:0]    o_estimate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lldc_pkg::CFG_W-1:0]    i_cfg_index_bits
);
    import lldc_pkg::*;

    localparam int QW = CMD_W + MAX_INDEX_BITS + RHO_W;

    logic [CFG_W-1:0]          r_index_bits;
    logic [BITS_W-1:0]         active_bits;
    logic                      cfg_fire;
    t_cfg_write                cfg_wr;
    logic                      q_space;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    logic [QW-1:0]             q_wdata;
    logic [QW-1:0]             q_rdata;
    t_cmd                      f_cmd;
    logic [MAX_INDEX_BITS-1:0] f_idx;
    logic [RHO_W-1:0]          f_rho;
    t_back_status              back_st;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign active_bits = f_active_bits(r_index_bits, MAX_INDEX_BITS);
    assign cfg_wr.we   = cfg_fire;
    assign cfg_wr.bits = f_active_bits(i_cfg_index_bits, MAX_INDEX_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= RESET_INDEX_BITS;
        end else if (cfg_fire) begin
            r_index_bits <= i_cfg_index_bits;
        end
    end

    lldc_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_front (
        .i_bits      (active_bits),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_hash_head (i_hash_head),
        .i_hash_tail (i_hash_tail),
        .i_space     (q_space),
        .o_push      (q_push),
        .o_cmd       (f_cmd),
        .o_idx       (f_idx),
        .o_rho       (f_rho)
    );

    assign q_wdata = {f_cmd, f_idx, f_rho};

    lldc_fifo #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    lldc_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bits       (active_bits),
        .i_cfg        (cfg_wr),
        .i_head_valid (q_valid),
        .i_head_cmd   (t_cmd'(q_rdata[QW-1 -: CMD_W])),
        .i_head_idx   (q_rdata[RHO_W +: MAX_INDEX_BITS]),
        .i_head_rho   (q_rdata[RHO_W-1:0]),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_estimate   (o_estimate),
        .o_status     (back_st)
    );

    a_cfg_restarts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> back_st.clearing)
        else $error("config write did not restart the clearing sweep");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> back_st.clearing && !o_out_valid && !back_st.s1_busy)
        else $error("reset did not start the sweep with an empty back end");

endmodule
